// File: sv/lpcsf_pkg.sv
// Package for the LPC synthesis / inverse filter core.
// Shared widths, request and register codes, sequencer states, store control struct.
// No dependencies.
package lpcsf_pkg;

    localparam int COEF_W        = 24;
    localparam int SMP_W         = 16;
    localparam int ORDER_W       = 6;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DW        = 6;
    localparam int MAX_ORDER_DEF = 32;
    localparam int COEF_FRAC_DEF = 16;
    localparam int ORDER_RST     = 16;
    localparam int SMP_MAX       = 32767;
    localparam int SMP_MIN       = -32768;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b1;

    // filter_mode values
    localparam logic MODE_SYNTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_TRUNC,
        ST_SAT
    } t_state;

    typedef struct packed {
        logic coef_we;
        logic hist_push;
        logic hist_clr;
        logic rd_en;
        logic rd_first;
    } t_store_ctl;

endpackage

// File: sv/lpc_synthesis_inverse_filter_core.sv
// LPC synthesis / inverse filter core. Filter request: the shared multiply-accumulate steps
// one tap per cycle through a two-stage read/multiply drain; the sum is then truncated and
// saturated into the output register, which waits while an earlier result is unaccepted. The
// next request is taken once the result is loaded. Load and clear requests give no result.
// Order clamps to MAX_ORDER. Reset (synchronous, active low) zeroes coefficients and history
// through valid bits at once, mode to synthesis, order to 16; o_ready is high right after reset.
module lpc_synthesis_inverse_filter_core #(
    parameter int MAX_ORDER      = lpcsf_pkg::MAX_ORDER_DEF,
    parameter int COEF_FRAC_BITS = lpcsf_pkg::COEF_FRAC_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [lpcsf_pkg::FUNC_W-1:0]           i_func,
    input  logic [lpcsf_pkg::ORDER_W-1:0]          i_coef_index,
    input  logic signed [lpcsf_pkg::COEF_W-1:0]    i_coef_value,
    input  logic signed [lpcsf_pkg::SMP_W-1:0]     i_sample,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [lpcsf_pkg::SMP_W-1:0]     o_out_sample,
    output logic                                   o_overflow,
    input  logic                                   i_cfg_we,
    input  logic [lpcsf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lpcsf_pkg::CFG_DW-1:0]           i_cfg_data
);

    localparam int A_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int K_W    = $clog2(MAX_ORDER + 1);
    localparam int ACC_W  = lpcsf_pkg::COEF_W + lpcsf_pkg::SMP_W + K_W;
    localparam int PW     = ACC_W - COEF_FRAC_BITS;
    localparam int YW     = PW + 1;
    localparam logic [ACC_W-1:0] BIAS = {{(ACC_W - COEF_FRAC_BITS){1'b0}},
                                         {COEF_FRAC_BITS{1'b1}}};
    localparam logic signed [YW-1:0] Y_MAX = YW'(lpcsf_pkg::SMP_MAX);
    localparam logic signed [YW-1:0] Y_MIN = YW'(lpcsf_pkg::SMP_MIN);

    lpcsf_pkg::t_state     r_state;
    lpcsf_pkg::t_state     n_state;
    lpcsf_pkg::t_store_ctl store_ctl;

    logic                                 r_mode;
    logic [lpcsf_pkg::ORDER_W-1:0]        r_order;
    logic [K_W-1:0]                       r_k;
    logic                                 r_rd_vld;
    logic signed [lpcsf_pkg::SMP_W-1:0]   r_x;
    logic signed [PW-1:0]                 r_pred;
    logic                                 r_out_valid;
    logic signed [lpcsf_pkg::SMP_W-1:0]   r_out_sample;
    logic                                 r_overflow;

    logic [K_W-1:0]                       ord_eff;
    logic                                 accept;
    logic                                 issue;
    logic                                 drained;
    logic                                 out_load;
    logic                                 mac_clr;
    logic [A_W-1:0]                       coef_addr;
    logic signed [lpcsf_pkg::COEF_W-1:0]  rd_coef;
    logic signed [lpcsf_pkg::SMP_W-1:0]   rd_hist;
    logic signed [ACC_W-1:0]              acc;
    logic                                 mac_busy;
    logic [ACC_W-1:0]                     acc_biased;
    logic signed [YW-1:0]                 y_sum;
    logic signed [lpcsf_pkg::SMP_W-1:0]   y_sat;
    logic                                 y_ovf;
    logic signed [lpcsf_pkg::SMP_W-1:0]   push_val;

    always_comb begin
        ord_eff = ({1'b0, r_order} > (lpcsf_pkg::ORDER_W + 1)'(MAX_ORDER))
                  ? K_W'(MAX_ORDER) : K_W'(r_order);
        issue   = (r_state == lpcsf_pkg::ST_RUN) && (r_k != ord_eff);
        drained = !issue && !r_rd_vld && !mac_busy;
        // index 1..MAX_ORDER maps to address 0..MAX_ORDER-1; the rest is dropped
        coef_addr = A_W'(i_coef_index - lpcsf_pkg::ORDER_W'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpcsf_pkg::ST_IDLE: begin
                if (i_valid && (i_func == lpcsf_pkg::FUNC_FILTER)) begin
                    n_state = lpcsf_pkg::ST_RUN;
                end
            end
            lpcsf_pkg::ST_RUN: begin
                if (drained) begin
                    n_state = lpcsf_pkg::ST_TRUNC;
                end
            end
            lpcsf_pkg::ST_TRUNC: begin
                n_state = lpcsf_pkg::ST_SAT;
            end
            lpcsf_pkg::ST_SAT: begin
                if (!r_out_valid || i_ready) begin
                    n_state = lpcsf_pkg::ST_IDLE;
                end
            end
            default: n_state = lpcsf_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_ready   = 1'b0;
        out_load  = 1'b0;
        store_ctl = '0;
        case (r_state)
            lpcsf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                store_ctl.coef_we = i_valid && (i_func == lpcsf_pkg::FUNC_LOAD)
                                    && (i_coef_index != '0)
                                    && ({1'b0, i_coef_index}
                                        <= (lpcsf_pkg::ORDER_W + 1)'(MAX_ORDER));
                store_ctl.hist_clr = i_valid && (i_func == lpcsf_pkg::FUNC_CLEAR);
            end
            lpcsf_pkg::ST_RUN: begin
                store_ctl.rd_en    = issue;
                store_ctl.rd_first = (r_k == '0);
            end
            lpcsf_pkg::ST_SAT: begin
                out_load            = !r_out_valid || i_ready;
                store_ctl.hist_push = out_load;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign accept  = i_valid && o_ready;
    assign mac_clr = accept && (i_func == lpcsf_pkg::FUNC_FILTER);

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        acc_biased = acc + (acc[ACC_W-1] ? BIAS : '0);
        if (r_mode == lpcsf_pkg::MODE_SYNTH) begin
            y_sum = YW'(r_x) + YW'(r_pred);
        end else begin
            y_sum = YW'(r_x) - YW'(r_pred);
        end
        y_ovf = 1'b1;
        if (y_sum > Y_MAX) begin
            y_sat = lpcsf_pkg::SMP_W'(lpcsf_pkg::SMP_MAX);
        end else if (y_sum < Y_MIN) begin
            y_sat = lpcsf_pkg::SMP_W'(lpcsf_pkg::SMP_MIN);
        end else begin
            y_sat = y_sum[lpcsf_pkg::SMP_W-1:0];
            y_ovf = 1'b0;
        end
        push_val = (r_mode == lpcsf_pkg::MODE_SYNTH) ? y_sat : r_x;
    end

    lpcsf_store #(
        .MAX_ORDER (MAX_ORDER),
        .A_W       (A_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (store_ctl),
        .i_coef_addr (coef_addr),
        .i_coef_data (i_coef_value),
        .i_hist_data (push_val),
        .i_rd_tap    (r_k[A_W-1:0]),
        .o_coef      (rd_coef),
        .o_hist      (rd_hist)
    );

    lpcsf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mac_clr),
        .i_vld   (r_rd_vld),
        .i_coef  (rd_coef),
        .i_hist  (rd_hist),
        .o_acc   (acc),
        .o_busy  (mac_busy)
    );

    always_ff @(posedge i_clk) begin
        if (mac_clr) begin
            r_x <= i_sample;
        end
        if (r_state == lpcsf_pkg::ST_TRUNC) begin
            r_pred <= acc_biased[ACC_W-1:COEF_FRAC_BITS];
        end
        if (out_load) begin
            r_out_sample <= y_sat;
            r_overflow   <= y_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpcsf_pkg::ST_IDLE;
            r_mode      <= lpcsf_pkg::MODE_SYNTH;
            r_order     <= lpcsf_pkg::ORDER_W'(lpcsf_pkg::ORDER_RST);
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (mac_clr) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= r_k + K_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lpcsf_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    lpcsf_pkg::CFG_ORDER: r_order <= i_cfg_data[lpcsf_pkg::ORDER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_overflow   = r_overflow;

`ifndef SYNTHESIS
    // the tap counter keeps its last value while idle, so only the loop is checked
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpcsf_pkg::ST_RUN) |-> (r_k <= ord_eff))
        else $error("tap counter ran past the predictor order");

    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == lpcsf_pkg::ST_RUN))
        else $error("history read in flight outside the tap loop");

    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_func == lpcsf_pkg::FUNC_FILTER))
        |=> (r_state == lpcsf_pkg::ST_RUN) && (r_k == '0))
        else $error("filter request did not start the tap loop");

    a_ovf_rails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow)
        |-> (o_out_sample == 16'sh7fff || o_out_sample == 16'sh8000))
        else $error("overflow flagged on a result that is not at a rail");
`endif

endmodule

// File: sv/lpcsf_store.sv
// Coefficient memory and circular signal-history memory with per-entry valid bits.
// Depends on lpcsf_pkg.
module lpcsf_store #(
    parameter int MAX_ORDER = lpcsf_pkg::MAX_ORDER_DEF,
    parameter int A_W       = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpcsf_pkg::t_store_ctl             i_ctl,
    input  logic [A_W-1:0]                    i_coef_addr,
    input  logic signed [lpcsf_pkg::COEF_W-1:0] i_coef_data,
    input  logic signed [lpcsf_pkg::SMP_W-1:0]  i_hist_data,
    input  logic [A_W-1:0]                    i_rd_tap,
    output logic signed [lpcsf_pkg::COEF_W-1:0] o_coef,
    output logic signed [lpcsf_pkg::SMP_W-1:0]  o_hist
);

    localparam logic [A_W-1:0] LAST = A_W'(MAX_ORDER - 1);

    logic signed [lpcsf_pkg::COEF_W-1:0] r_coef_mem [MAX_ORDER];
    logic signed [lpcsf_pkg::SMP_W-1:0]  r_hist_mem [MAX_ORDER];
    logic [MAX_ORDER-1:0]                r_cvld;
    logic [MAX_ORDER-1:0]                r_hvld;
    logic [A_W-1:0]                      r_head;
    logic [A_W-1:0]                      r_rp;
    logic signed [lpcsf_pkg::COEF_W-1:0] r_coef_q;
    logic signed [lpcsf_pkg::SMP_W-1:0]  r_hist_q;
    logic                                r_cq_vld;
    logic                                r_hq_vld;
    logic [A_W-1:0]                      base;
    logic [A_W-1:0]                      haddr;

    // tap k sits one slot behind the previous tap, newest just behind the head
    always_comb begin
        base  = i_ctl.rd_first ? r_head : r_rp;
        haddr = (base == '0) ? LAST : base - A_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.coef_we) begin
            r_coef_mem[i_coef_addr] <= i_coef_data;
        end
        if (i_ctl.hist_push) begin
            r_hist_mem[r_head] <= i_hist_data;
        end
        if (i_ctl.rd_en) begin
            r_coef_q <= r_coef_mem[i_rd_tap];
            r_hist_q <= r_hist_mem[haddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvld   <= '0;
            r_hvld   <= '0;
            r_head   <= '0;
            r_rp     <= '0;
            r_cq_vld <= 1'b0;
            r_hq_vld <= 1'b0;
        end else begin
            if (i_ctl.coef_we) begin
                r_cvld[i_coef_addr] <= 1'b1;
            end
            if (i_ctl.hist_clr) begin
                r_hvld <= '0;
            end else if (i_ctl.hist_push) begin
                r_hvld[r_head] <= 1'b1;
                r_head         <= (r_head == LAST) ? '0 : r_head + A_W'(1);
            end
            if (i_ctl.rd_en) begin
                r_rp     <= haddr;
                r_cq_vld <= r_cvld[i_rd_tap];
                r_hq_vld <= r_hvld[haddr];
            end
        end
    end

    assign o_coef = r_cq_vld ? r_coef_q : '0;
    assign o_hist = r_hq_vld ? r_hist_q : '0;

endmodule

// File: sv/lpcsf_mac.sv
// Shared multiply-accumulate unit: registered 24x16 product, then accumulate.
// Depends on lpcsf_pkg.
module lpcsf_mac #(
    parameter int ACC_W = 46
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clr,
    input  logic                                i_vld,
    input  logic signed [lpcsf_pkg::COEF_W-1:0] i_coef,
    input  logic signed [lpcsf_pkg::SMP_W-1:0]  i_hist,
    output logic signed [ACC_W-1:0]             o_acc,
    output logic                                o_busy
);

    localparam int PROD_W = lpcsf_pkg::COEF_W + lpcsf_pkg::SMP_W;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * i_hist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_vld;
            if (i_clr) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_pv;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for lpc_synthesis_inverse_filter_core.
// Queue-fed request driver, result monitor with an in-bench filter predictor, register phases.
// Depends on lpcsf_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [lpcsf_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic              MODE_INV    = 1'b1;
    localparam int SETTLE_CYCLES  = 48;     // beyond the longest filter request at order 32
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 11;
    localparam int PHASE_ITEMS    = 150;

    typedef struct {
        logic [lpcsf_pkg::FUNC_W-1:0]         func;
        logic [lpcsf_pkg::ORDER_W-1:0]        coef_index;
        logic signed [lpcsf_pkg::COEF_W-1:0]  coef_value;
        logic signed [lpcsf_pkg::SMP_W-1:0]   sample;
        bit                                   drain_first;  // hold until all results are back
    } t_lpc_request;

    typedef struct {
        logic signed [lpcsf_pkg::SMP_W-1:0] out_sample;
        logic                               overflow;
    } t_sample_result;

    logic                                  i_clk        = 1'b0;
    logic                                  i_rst_n      = 1'b0;
    logic                                  i_valid      = 1'b0;
    logic                                  o_ready;
    logic [lpcsf_pkg::FUNC_W-1:0]          i_func       = '0;
    logic [lpcsf_pkg::ORDER_W-1:0]         i_coef_index = '0;
    logic signed [lpcsf_pkg::COEF_W-1:0]   i_coef_value = '0;
    logic signed [lpcsf_pkg::SMP_W-1:0]    i_sample     = '0;
    logic                                  o_valid;
    logic                                  i_ready      = 1'b0;
    logic signed [lpcsf_pkg::SMP_W-1:0]    o_out_sample;
    logic                                  o_overflow;
    logic                                  i_cfg_we     = 1'b0;
    logic [lpcsf_pkg::CFG_IDX_W-1:0]       i_cfg_idx    = '0;
    logic [lpcsf_pkg::CFG_DW-1:0]          i_cfg_data   = '0;

    t_lpc_request   pending_requests[$];
    t_sample_result expected_outputs[$];
    t_lpc_request   in_flight;

    // predictor state
    logic signed [lpcsf_pkg::COEF_W-1:0] coef_store[lpcsf_pkg::MAX_ORDER_DEF];
    logic signed [lpcsf_pkg::SMP_W-1:0]  sample_hist[lpcsf_pkg::MAX_ORDER_DEF];
    logic                                mode_q  = lpcsf_pkg::MODE_SYNTH;
    logic [lpcsf_pkg::ORDER_W-1:0]       order_q = lpcsf_pkg::ORDER_W'(lpcsf_pkg::ORDER_RST);

    bit quiet    = 1'b0;
    int idle_pct = 0;
    int fail_count   = 0;
    int send_gap     = 0;
    int ready_gap    = 0;
    int stall_cycles = 0;

    lpc_synthesis_inverse_filter_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_sample (o_out_sample),
        .o_overflow   (o_overflow),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Apply one accepted request to the predictor; filter requests produce one expectation.
    function automatic void filter_step(input t_lpc_request req);
        t_sample_result res;
        longint acc;
        longint pred;
        longint y;
        int n;
        case (req.func)
            lpcsf_pkg::FUNC_LOAD: begin
                if (req.coef_index >= 1 && req.coef_index <= lpcsf_pkg::MAX_ORDER_DEF)
                    coef_store[req.coef_index - 1] = req.coef_value;
            end
            lpcsf_pkg::FUNC_CLEAR: begin
                foreach (sample_hist[k]) sample_hist[k] = '0;
            end
            lpcsf_pkg::FUNC_FILTER: begin
                n = (order_q > lpcsf_pkg::MAX_ORDER_DEF) ? lpcsf_pkg::MAX_ORDER_DEF
                                                         : int'(order_q);
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc += longint'(coef_store[k]) * longint'(sample_hist[k]);
                // signed divide truncates toward zero
                pred = acc / (longint'(1) << lpcsf_pkg::COEF_FRAC_DEF);
                y = (mode_q == lpcsf_pkg::MODE_SYNTH) ? longint'(req.sample) + pred
                                                      : longint'(req.sample) - pred;
                res.overflow = (y > lpcsf_pkg::SMP_MAX) || (y < lpcsf_pkg::SMP_MIN);
                if (y > lpcsf_pkg::SMP_MAX) y = lpcsf_pkg::SMP_MAX;
                else if (y < lpcsf_pkg::SMP_MIN) y = lpcsf_pkg::SMP_MIN;
                res.out_sample = lpcsf_pkg::SMP_W'(y);
                for (int k = lpcsf_pkg::MAX_ORDER_DEF - 1; k > 0; k--)
                    sample_hist[k] = sample_hist[k - 1];
                sample_hist[0] = (mode_q == lpcsf_pkg::MODE_SYNTH) ? res.out_sample
                                                                   : req.sample;
                expected_outputs.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_request(input logic [lpcsf_pkg::FUNC_W-1:0] func,
                                          input logic [lpcsf_pkg::ORDER_W-1:0] idx,
                                          input logic signed [lpcsf_pkg::COEF_W-1:0] value,
                                          input logic signed [lpcsf_pkg::SMP_W-1:0] smp,
                                          input bit drain);
        t_lpc_request r;
        r.func        = func;
        r.coef_index  = idx;
        r.coef_value  = value;
        r.sample      = smp;
        r.drain_first = drain;
        pending_requests.push_back(r);
    endfunction

    function automatic logic signed [lpcsf_pkg::SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return lpcsf_pkg::SMP_W'(lpcsf_pkg::SMP_MAX);
            1:       return lpcsf_pkg::SMP_W'(lpcsf_pkg::SMP_MIN);
            2, 3, 4: return lpcsf_pkg::SMP_W'($urandom);
            default: return lpcsf_pkg::SMP_W'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic signed [lpcsf_pkg::COEF_W-1:0] pick_coef(input int span);
        return lpcsf_pkg::COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic write_reg(input logic [lpcsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpcsf_pkg::CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == lpcsf_pkg::CFG_MODE) mode_q = data[0];
        else order_q = lpcsf_pkg::ORDER_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sampled at the falling edge so driver updates from the rising edge are visible.
    task automatic wait_idle();
        while (pending_requests.size() > 0 || i_valid || expected_outputs.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver
    always @(posedge i_clk) begin : driver
        logic holding;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            holding = i_valid;
            if (i_valid && o_ready) begin
                filter_step(in_flight);
                holding = 1'b0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain_first &&
                               expected_outputs.size() > 0)) begin
                    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                        send_gap = $urandom_range(0, 4);
                    end else begin
                        in_flight = pending_requests.pop_front();
                        i_func       <= in_flight.func;
                        i_coef_index <= in_flight.coef_index;
                        i_coef_value <= in_flight.coef_value;
                        i_sample     <= in_flight.sample;
                        holding = 1'b1;
                    end
                end
            end
            i_valid <= holding;
        end
    end

    // Result monitor and ready stalls
    always @(posedge i_clk) begin : monitor
        t_sample_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outputs.size() == 0) begin
                report_failure($sformatf("unexpected result out_sample=%0d overflow=%0b",
                                         o_out_sample, o_overflow));
            end else begin
                want = expected_outputs.pop_front();
                if (o_out_sample !== want.out_sample)
                    report_failure($sformatf("out_sample exp %0d got %0d",
                                             want.out_sample, o_out_sample));
                if (o_overflow !== want.overflow)
                    report_failure($sformatf("overflow exp %0b got %0b (out_sample %0d)",
                                             want.overflow, o_overflow, want.out_sample));
            end
        end
        if (ready_gap > 0) begin
            ready_gap--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            ready_gap = $urandom_range(0, 4);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int count;
        int run;
        int span;
        int taps;
        int nfunc;
        logic [lpcsf_pkg::ORDER_W-1:0] order_sel;

        foreach (coef_store[k]) coef_store[k] = '0;
        foreach (sample_hist[k]) sample_hist[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings (synthesis, order 16), zero taps pass samples through
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd32767, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, -16'sd32768, 1'b0);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd1, 24'sd8388607, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd32, -24'sd8388608, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd0, 24'sd12345, 16'sd0, 1'b0);    // ignored index
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd33, 24'sd4096, 16'sd0, 1'b0);    // ignored index
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd63, 24'sd8388607, 16'sd0, 1'b0); // ignored index
        queue_request(FUNC_UNUSED, 6'd5, 24'sd777, 16'sd99, 1'b0);              // no-op
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd1, 1'b0);          // saturates low
        queue_request(lpcsf_pkg::FUNC_CLEAR, 6'd0, '0, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd5, 1'b1);
        wait_idle();

        // order zero: no prediction even with taps loaded
        write_reg(lpcsf_pkg::CFG_ORDER, 6'd0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd32767, 1'b0);
        wait_idle();

        // order above max clamps; inverse mode keeps taps and history
        write_reg(lpcsf_pkg::CFG_ORDER, 6'd63);
        write_reg(lpcsf_pkg::CFG_MODE, {5'b11111, MODE_INV});
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd1, 24'sd65536, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd2, -24'sd32768, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, -16'sd32768, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd3, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd2, -24'sd1, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd1, 1'b0); // tiny negative sum
        wait_idle();

        write_reg(lpcsf_pkg::CFG_MODE, {5'b00000, lpcsf_pkg::MODE_SYNTH});
        write_reg(lpcsf_pkg::CFG_ORDER, 6'd1);
        queue_request(lpcsf_pkg::FUNC_LOAD, 6'd1, 24'sd32768, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd1000, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, 16'sd0, 1'b0);
        queue_request(lpcsf_pkg::FUNC_FILTER, 6'd0, '0, -16'sd1, 1'b0);
        wait_idle();

        // Random phases: mostly load-a-tap-set-then-filter runs, some noise requests
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            quiet    = (phase == RAND_PHASES - 1);
            idle_pct = quiet ? 0 : ((phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 10 : 35));
            write_reg(lpcsf_pkg::CFG_MODE, lpcsf_pkg::CFG_DW'($urandom_range(0, 63)));
            case ($urandom_range(0, 5))
                0:       order_sel = 6'd0;
                1:       order_sel = 6'd32;
                2:       order_sel = 6'd63;
                3:       order_sel = lpcsf_pkg::ORDER_W'($urandom_range(1, 4));
                default: order_sel = lpcsf_pkg::ORDER_W'($urandom_range(0, 63));
            endcase
            write_reg(lpcsf_pkg::CFG_ORDER, lpcsf_pkg::CFG_DW'(order_sel));
            taps = (order_sel > lpcsf_pkg::MAX_ORDER_DEF) ? lpcsf_pkg::MAX_ORDER_DEF
                                                          : int'(order_sel);
            count = 0;
            while (count < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 75) begin
                    if ($urandom_range(0, 1)) begin
                        queue_request(lpcsf_pkg::FUNC_CLEAR, lpcsf_pkg::ORDER_W'($urandom),
                                      lpcsf_pkg::COEF_W'($urandom),
                                      lpcsf_pkg::SMP_W'($urandom),
                                      $urandom_range(0, 99) == 0);
                        count++;
                    end
                    case ($urandom_range(0, 3))
                        0:       span = 256;
                        1:       span = 65536 / (taps + 1);
                        2:       span = 65536;
                        default: span = 8388607;
                    endcase
                    for (int k = 1; k <= taps; k++) begin
                        // each tap loaded on its own: on a coin toss, else one time in four
                        if ($urandom_range(0, 1) || $urandom_range(0, 3) == 0) begin
                            queue_request(lpcsf_pkg::FUNC_LOAD, lpcsf_pkg::ORDER_W'(k),
                                          pick_coef(span), lpcsf_pkg::SMP_W'($urandom),
                                          1'b0);
                            count++;
                        end
                    end
                    run = $urandom_range(4, 30);
                    for (int k = 0; k < run; k++) begin
                        queue_request(lpcsf_pkg::FUNC_FILTER, lpcsf_pkg::ORDER_W'($urandom),
                                      lpcsf_pkg::COEF_W'($urandom), pick_sample(),
                                      $urandom_range(0, 99) == 0);
                        count++;
                    end
                end else begin
                    nfunc = $urandom_range(0, 3);
                    queue_request(lpcsf_pkg::FUNC_W'(nfunc), lpcsf_pkg::ORDER_W'($urandom),
                                  lpcsf_pkg::COEF_W'($urandom), lpcsf_pkg::SMP_W'($urandom),
                                  1'b0);
                    if (lpcsf_pkg::FUNC_W'(nfunc) != FUNC_UNUSED) count++;
                end
            end
            wait_idle();
        end

        if (expected_outputs.size() > 0)
            report_failure($sformatf("%0d expected results never arrived",
                                     expected_outputs.size()));
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("ERROR: %0d mismatches", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/lpcsf_pkg.sv
sv/lpcsf_store.sv
sv/lpcsf_mac.sv
sv/lpc_synthesis_inverse_filter_core.sv
tb/tb_top.sv
